/* rtl/wtsp_pkg.sv */
// ----------------------------------------------------------------------------
// wtsp_pkg
// Shared widths, constants and register indexes of the world-to-screen
// projection pipeline.
// ----------------------------------------------------------------------------
package wtsp_pkg;

  localparam int COEF_W   = 32;
  localparam int DIM_W    = 14;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CLIP_W   = 49;
  localparam int MAG_W    = 48;
  localparam int FRAC_W   = 16;
  localparam int DIV_NUM_W = MAG_W + FRAC_W;
  localparam int TERM_W   = 42;
  localparam int SCR_W    = TERM_W + DIM_W;

  localparam logic signed [CLIP_W-1:0] W_MIN = CLIP_W'(6554);
  localparam logic signed [DIV_NUM_W+1:0] ONE_Q16 = (DIV_NUM_W+2)'(65536);
  localparam logic signed [DIV_NUM_W+1:0] TERM_LIM = (DIV_NUM_W+2)'(64'd1 << 40);

  localparam logic [CFG_IDX_W-1:0] REG_X_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_B  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_W_A  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_W_B  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd7;

endpackage

/* rtl/world_to_screen_projection.sv */
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Projects a Q16.16 world point through three matrix rows, divides by clip W
// and maps the result to viewport pixels in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries point_x/y/z. Output channel
//   out_valid/out_stall carries visible, screen_x, screen_y. One request in
//   gives exactly one request out, in order.
//   Configuration: cfg_valid/cfg_ready (always ready) with cfg_index and
//   cfg_data; write only while the pipeline is empty.
//   Stages: multiply, row sum, prep, 64 divider stages, term, viewport
//   multiply, saturate. Throughput: one point per cycle while no result
//   waits under out_stall; the 64-stage bit-per-stage divider sets the latency.
//   Reset clears all valid bits, matrix coefficients to 0, width 1920 and
//   height 1080.
//   When out_stall is high with a result waiting, the whole pipeline holds
//   and in_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module world_to_screen_projection (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [wtsp_pkg::COEF_W-1:0]   in_point_x,
  input  logic signed [wtsp_pkg::COEF_W-1:0]   in_point_y,
  input  logic signed [wtsp_pkg::COEF_W-1:0]   in_point_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_visible,
  output logic signed [wtsp_pkg::COEF_W-1:0]   out_screen_x,
  output logic signed [wtsp_pkg::COEF_W-1:0]   out_screen_y,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wtsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wtsp_pkg::CFG_W-1:0]           cfg_data
);

  localparam int NW = wtsp_pkg::DIV_NUM_W;
  localparam int SW = wtsp_pkg::SCR_W;

  logic [wtsp_pkg::CFG_W-1:0] mat_r [6];
  logic [wtsp_pkg::DIM_W-1:0] width_r, height_r;
  logic en;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) mat_r[i] <= '0;
      width_r  <= wtsp_pkg::DIM_W'(1920);
      height_r <= wtsp_pkg::DIM_W'(1080);
    end else if (cfg_valid) begin
      case (cfg_index)
        wtsp_pkg::REG_X_A:    mat_r[0] <= cfg_data;
        wtsp_pkg::REG_X_B:    mat_r[1] <= cfg_data;
        wtsp_pkg::REG_Y_A:    mat_r[2] <= cfg_data;
        wtsp_pkg::REG_Y_B:    mat_r[3] <= cfg_data;
        wtsp_pkg::REG_W_A:    mat_r[4] <= cfg_data;
        wtsp_pkg::REG_W_B:    mat_r[5] <= cfg_data;
        wtsp_pkg::REG_WIDTH:  width_r  <= cfg_data[wtsp_pkg::DIM_W-1:0];
        wtsp_pkg::REG_HEIGHT: height_r <= cfg_data[wtsp_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: products
  logic signed [31:0] coef [3][3];
  logic signed [31:0] offs [3];
  logic signed [31:0] pt [3];
  logic signed [63:0] prod_r [3][3];
  logic signed [31:0] offs_r [3];
  logic v1_r;

  always_comb begin
    pt[0] = in_point_x;
    pt[1] = in_point_y;
    pt[2] = in_point_z;
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = mat_r[2*r][31:0];
      coef[r][1] = mat_r[2*r][63:32];
      coef[r][2] = mat_r[2*r+1][31:0];
      offs[r]    = mat_r[2*r+1][63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) prod_r[r][c] <= coef[r][c] * pt[c];
        offs_r[r] <= offs[r];
      end
    end
  end

  // stage 2: row sums with floored products
  logic signed [wtsp_pkg::CLIP_W-1:0] clip_r [3];
  logic v2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        clip_r[r] <= $signed({prod_r[r][0][63], prod_r[r][0][63:16]})
                   + $signed({prod_r[r][1][63], prod_r[r][1][63:16]})
                   + $signed({prod_r[r][2][63], prod_r[r][2][63:16]})
                   + wtsp_pkg::CLIP_W'(offs_r[r]);
      end
    end
  end

  // stage 3: visibility, magnitudes
  logic v3_r, vis3_r, nx3_r, ny3_r;
  logic [NW-1:0] numx3_r, numy3_r;
  logic [wtsp_pkg::MAG_W-1:0] den3_r;
  logic [wtsp_pkg::CLIP_W-1:0] magx, magy;

  assign magx = clip_r[0][wtsp_pkg::CLIP_W-1] ? -clip_r[0] : clip_r[0];
  assign magy = clip_r[1][wtsp_pkg::CLIP_W-1] ? -clip_r[1] : clip_r[1];

  always_ff @(posedge clk) begin
    if (en) begin
      vis3_r  <= clip_r[2] >= wtsp_pkg::W_MIN;
      nx3_r   <= clip_r[0][wtsp_pkg::CLIP_W-1];
      ny3_r   <= clip_r[1][wtsp_pkg::CLIP_W-1];
      numx3_r <= {magx[wtsp_pkg::MAG_W-1:0], {wtsp_pkg::FRAC_W{1'b0}}};
      numy3_r <= {magy[wtsp_pkg::MAG_W-1:0], {wtsp_pkg::FRAC_W{1'b0}}};
      den3_r  <= clip_r[2][wtsp_pkg::MAG_W-1:0];
    end
  end

  // divider stages
  logic [NW-1:0] qx, qy;

  wtsp_div #(.NUM_W(NW), .DEN_W(wtsp_pkg::MAG_W)) u_div_x (
    .clk(clk), .en(en), .num(numx3_r), .den(den3_r), .quo(qx)
  );
  wtsp_div #(.NUM_W(NW), .DEN_W(wtsp_pkg::MAG_W)) u_div_y (
    .clk(clk), .en(en), .num(numy3_r), .den(den3_r), .quo(qy)
  );

  logic dv_r [NW], dvis_r [NW], dnx_r [NW], dny_r [NW];

  always_ff @(posedge clk) begin
    if (en) begin
      dvis_r[0] <= vis3_r;
      dnx_r[0]  <= nx3_r;
      dny_r[0]  <= ny3_r;
      for (int i = 1; i < NW; i++) begin
        dvis_r[i] <= dvis_r[i-1];
        dnx_r[i]  <= dnx_r[i-1];
        dny_r[i]  <= dny_r[i-1];
      end
    end
  end

  // stage 4: viewport terms, clamped
  logic signed [NW+1:0] sqx, sqy, tx, ty;
  logic signed [wtsp_pkg::TERM_W-1:0] tx4_r, ty4_r;
  logic v4_r, vis4_r;

  assign sqx = dnx_r[NW-1] ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
  assign sqy = dny_r[NW-1] ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
  assign tx  = sqx + wtsp_pkg::ONE_Q16;
  assign ty  = wtsp_pkg::ONE_Q16 - sqy;

  always_ff @(posedge clk) begin
    if (en) begin
      vis4_r <= dvis_r[NW-1];
      if (tx > wtsp_pkg::TERM_LIM)       tx4_r <= wtsp_pkg::TERM_W'(wtsp_pkg::TERM_LIM);
      else if (tx < -wtsp_pkg::TERM_LIM) tx4_r <= wtsp_pkg::TERM_W'(-wtsp_pkg::TERM_LIM);
      else                               tx4_r <= wtsp_pkg::TERM_W'(tx);
      if (ty > wtsp_pkg::TERM_LIM)       ty4_r <= wtsp_pkg::TERM_W'(wtsp_pkg::TERM_LIM);
      else if (ty < -wtsp_pkg::TERM_LIM) ty4_r <= wtsp_pkg::TERM_W'(-wtsp_pkg::TERM_LIM);
      else                               ty4_r <= wtsp_pkg::TERM_W'(ty);
    end
  end

  // stage 5: scale by dimension
  logic signed [SW-1:0] sx5_r, sy5_r;
  logic v5_r, vis5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vis5_r <= vis4_r;
      sx5_r  <= SW'(tx4_r) * SW'($signed({1'b0, width_r}));
      sy5_r  <= SW'(ty4_r) * SW'($signed({1'b0, height_r}));
    end
  end

  // stage 6: halve, saturate, output
  logic signed [SW-1:0] hx, hy;
  logic signed [31:0] satx, saty;

  assign hx = sx5_r >>> 1;
  assign hy = sy5_r >>> 1;

  always_comb begin
    if (hx > SW'(64'sd2147483647))       satx = 32'sh7fffffff;
    else if (hx < -SW'(64'sd2147483648)) satx = 32'sh80000000;
    else                                  satx = hx[31:0];
    if (hy > SW'(64'sd2147483647))       saty = 32'sh7fffffff;
    else if (hy < -SW'(64'sd2147483648)) saty = 32'sh80000000;
    else                                  saty = hy[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_visible  <= vis5_r;
      out_screen_x <= vis5_r ? satx : '0;
      out_screen_y <= vis5_r ? saty : '0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      for (int i = 0; i < NW; i++) dv_r[i] <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      dv_r[0] <= v3_r;
      for (int i = 1; i < NW; i++) dv_r[i] <= dv_r[i-1];
      v4_r <= dv_r[NW-1];
      v5_r <= v4_r;
      out_valid <= v5_r;
    end
  end

endmodule

/* rtl/wtsp_div.sv */
// ----------------------------------------------------------------------------
// wtsp_div
// Pipelined restoring divider, one quotient bit per stage, global enable.
// ----------------------------------------------------------------------------
module wtsp_div #(
  parameter int NUM_W = wtsp_pkg::DIV_NUM_W,
  parameter int DEN_W = wtsp_pkg::MAG_W
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [DEN_W:0]   rem_r [1:NUM_W];
  logic [NUM_W-1:0] num_r [1:NUM_W];
  logic [NUM_W-1:0] quo_r [1:NUM_W];
  logic [DEN_W-1:0] den_r [1:NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W:0]   rem_q;
    logic [NUM_W-1:0] num_q;
    logic [NUM_W-1:0] quo_q;
    logic [DEN_W-1:0] den_q;
    logic [DEN_W:0]   sh;
    logic             ge;
    if (i == 0) begin : g_in
      assign rem_q = '0;
      assign num_q = num;
      assign quo_q = '0;
      assign den_q = den;
    end else begin : g_pipe
      assign rem_q = rem_r[i];
      assign num_q = num_r[i];
      assign quo_q = quo_r[i];
      assign den_q = den_r[i];
    end
    assign sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
    assign ge = sh >= {1'b0, den_q};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? sh - {1'b0, den_q} : sh;
        num_r[i+1] <= {num_q[NUM_W-2:0], 1'b0};
        quo_r[i+1] <= {quo_q[NUM_W-2:0], ge};
        den_r[i+1] <= den_q;
      end
    end
  end

  assign quo = quo_r[NUM_W];

endmodule

/* verif/tb_world_to_screen_projection.sv */
// ----------------------------------------------------------------------------
// tb_world_to_screen_projection
// Drives projected points through the pipeline under random input gaps and
// output stalls, predicts visibility and viewport pixels per point, and
// checks each result in order. Matrix and viewport settings change between
// phases while the pipeline is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_world_to_screen_projection;

  typedef struct {
    logic        visible;
    logic [31:0] sx;
    logic [31:0] sy;
  } screen_pt_t;

  int unsigned mismatches;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  class projection_board;
    logic [63:0] mat[8];
    screen_pt_t  pending[$];

    function void reset_regs();
      foreach (mat[i]) mat[i] = '0;
      mat[wtsp_pkg::REG_WIDTH]  = 64'd1920;
      mat[wtsp_pkg::REG_HEIGHT] = 64'd1080;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      if (idx == wtsp_pkg::REG_WIDTH || idx == wtsp_pkg::REG_HEIGHT) val &= 64'h3FFF;
      mat[idx] = val;
    endfunction

    function longint floor16(longint v);
      return v >>> 16;
    endfunction

    function longint row(logic [63:0] a, logic [63:0] b,
                         longint px, longint py, longint pz);
      longint c0, c1, c2, off;
      c0 = longint'($signed(a[31:0]));
      c1 = longint'($signed(a[63:32]));
      c2 = longint'($signed(b[31:0]));
      off = longint'($signed(b[63:32]));
      return floor16(px * c0) + floor16(py * c1) + floor16(pz * c2) + off;
    endfunction

    function longint divq(longint num, longint den);
      logic [127:0] mag, q;
      mag = num < 0 ? 128'(-num) : 128'(num);
      q = (mag << 16) / 128'(den);
      return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function logic [31:0] viewport(longint term, logic [63:0] dim);
      longint v;
      if (term > (64'sd1 <<< 40)) term = 64'sd1 <<< 40;
      if (term < -(64'sd1 <<< 40)) term = -(64'sd1 <<< 40);
      v = (term * longint'(dim[13:0])) >>> 1;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      longint px, py, pz, cx, cy, cw;
      screen_pt_t e;
      px = longint'($signed(x));
      py = longint'($signed(y));
      pz = longint'($signed(z));
      cx = row(mat[wtsp_pkg::REG_X_A], mat[wtsp_pkg::REG_X_B], px, py, pz);
      cy = row(mat[wtsp_pkg::REG_Y_A], mat[wtsp_pkg::REG_Y_B], px, py, pz);
      cw = row(mat[wtsp_pkg::REG_W_A], mat[wtsp_pkg::REG_W_B], px, py, pz);
      if (cw < 6554) begin
        e = '{1'b0, 32'd0, 32'd0};
      end else begin
        e.visible = 1'b1;
        e.sx = viewport(divq(cx, cw) + 65536, mat[wtsp_pkg::REG_WIDTH]);
        e.sy = viewport(65536 - divq(cy, cw), mat[wtsp_pkg::REG_HEIGHT]);
      end
      pending.push_back(e);
    endfunction

    task check_result(logic vis, logic [31:0] sx, logic [31:0] sy);
      screen_pt_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected request", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (vis !== e.visible) report_mismatch("visible", vis, e.visible);
      if (sx !== e.sx) report_mismatch("screen_x", sx, e.sx);
      if (sy !== e.sy) report_mismatch("screen_y", sy, e.sy);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall;
  logic signed [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid, out_stall = 1'b0, out_visible;
  logic signed [31:0] out_screen_x, out_screen_y;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  projection_board board = new();
  longint unsigned cycles;
  int stall_mode;

  world_to_screen_projection dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stall pattern and result checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        board.check_result(out_visible, out_screen_x, out_screen_y);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= (cycles[3:0] < 4'd9);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_valid   <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    do @(posedge clk); while (in_stall);
    board.note_point(x, y, z);
  endtask

  task automatic send_burst(int n, bit gaps);
    int left;
    left = n;
    while (left > 0) begin
      int run;
      run = gaps ? $urandom_range(1, 12) : left;
      if (run > left) run = left;
      repeat (run) send_point(pick_coord(), pick_coord(), pick_coord());
      left -= run;
      if (gaps && $urandom_range(0, 1)) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [63:0] pair(int lo, int hi);
    return {32'(hi), 32'(lo)};
  endfunction

  task automatic load_matrix(int scale, int w_lo, int w_hi, int dimx, int dimy);
    write_reg(wtsp_pkg::REG_X_A, pair(scale, $urandom_range(0, 1 << 14)));
    write_reg(wtsp_pkg::REG_X_B,
              pair(-($urandom_range(0, 1 << 14)), $urandom_range(0, 1 << 18)));
    write_reg(wtsp_pkg::REG_Y_A, pair($urandom_range(0, 1 << 14), scale));
    write_reg(wtsp_pkg::REG_Y_B,
              pair($urandom_range(0, 1 << 14), -($urandom_range(0, 1 << 18))));
    write_reg(wtsp_pkg::REG_W_A, pair(w_lo, $urandom_range(0, 1 << 12)));
    write_reg(wtsp_pkg::REG_W_B, pair(w_hi, $urandom_range(0, 30) << 16));
    write_reg(wtsp_pkg::REG_WIDTH, 64'(dimx));
    write_reg(wtsp_pkg::REG_HEIGHT, 64'(dimy));
  endtask

  initial begin
    board.reset_regs();
    cycles = 0;
    stall_mode = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset matrix: W is zero, nothing visible
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    in_valid <= 1'b0;
    drain();

    // identity-like, W from z; edge cases around the W threshold
    write_reg(wtsp_pkg::REG_X_A, pair(1 << 16, 0));
    write_reg(wtsp_pkg::REG_X_B, pair(0, 0));
    write_reg(wtsp_pkg::REG_Y_A, pair(0, 1 << 16));
    write_reg(wtsp_pkg::REG_Y_B, pair(0, 0));
    write_reg(wtsp_pkg::REG_W_A, pair(0, 0));
    write_reg(wtsp_pkg::REG_W_B, pair(1 << 16, 0));
    write_reg(wtsp_pkg::REG_WIDTH, 64'd8192);
    write_reg(wtsp_pkg::REG_HEIGHT, 64'd1);
    send_point(32'h0, 32'h0, 32'd6554);
    send_point(32'h0, 32'h0, 32'd6553);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd6554);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd6554);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);
    send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000);
    in_valid <= 1'b0;
    drain();

    // extreme coefficients and a zero width
    write_reg(wtsp_pkg::REG_X_A, 64'hFFFF_FFFF_8000_0000);
    write_reg(wtsp_pkg::REG_X_B, 64'h7FFF_FFFF_7FFF_FFFF);
    write_reg(wtsp_pkg::REG_Y_A, 64'h8000_0000_7FFF_FFFF);
    write_reg(wtsp_pkg::REG_Y_B, 64'h8000_0000_8000_0000);
    write_reg(wtsp_pkg::REG_W_B, pair(1 << 16, 6554));
    write_reg(wtsp_pkg::REG_WIDTH, 64'd0);
    write_reg(wtsp_pkg::REG_HEIGHT, 64'h3FFF);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    send_point(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_8000);
    in_valid <= 1'b0;
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      stall_mode = phase % 4;
      case (phase)
        0: load_matrix(1 << 16, 0, 1 << 16, 1920, 1080);
        1: load_matrix(3 << 16, 1 << 12, -(1 << 16), 8192, 8192);
        2: load_matrix(1 << 10, -(1 << 10), 1 << 14, 1, 1);
        3: load_matrix(-(1 << 16), 1 << 15, 1 << 16, 640, 480);
        4: load_matrix($urandom, $urandom, $urandom, 16383, 0);
        default: load_matrix(1 << 16, 0, 1 << 16, $urandom_range(1, 8192),
                             $urandom_range(1, 8192));
      endcase
      send_burst(150, phase != 0);
      drain();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
